### sv/sovl_pkg.sv
`default_nettype none
package sovl_pkg;

    localparam int W_W       = 108;
    localparam int MUL_W     = 64;
    localparam int PROD_W    = 128;
    localparam int DIV_NUM_W = 46;
    localparam int DIV_DEN_W = 33;
    localparam int SQ_W      = 63;
    localparam int ROOT_W    = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [63:0] EPS_Q32 = 64'd429497;
    localparam logic [21:0] YAW_RECIP = 22'd2982617;
    localparam int          YAW_RECIP_SH = 27;

    localparam logic [CFG_ADDR_W-1:0] CFG_RADIUS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_YAW_TGT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALT_TGT  = 3'd3;

    typedef enum logic [3:0] {
        OP_X2, OP_Y2, OP_X3, OP_Y3, OP_X4, OP_Y4, OP_R2, OP_R4,
        OP_T1X, OP_T2X, OP_T1Y, OP_T2Y, OP_EPS, OP_WX2, OP_WY2
    } mul_op_t;

    typedef enum logic [1:0] {
        DV_X, DV_Y
    } div_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_SUM_A, ST_ADD_WX, ST_ADD_WY, ST_NORM,
        ST_SQRT_GO, ST_SQRT_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_FINISH
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    mul_go;
        mul_op_t mul_op;
        logic    sum_a;
        logic    add_wx;
        logic    add_wy;
        logic    norm_step;
        logic    sqrt_go;
        logic    div_go;
        div_op_t div_op;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic hold_case;
        logic mul_done;
        logic norm_done;
        logic sqrt_done;
        logic div_done;
    } dp_stat_t;

endpackage
`default_nettype wire

### sv/superellipse_orbit_velocity_law_core.sv
// From the accepting edge to out_valid a pose takes fifteen 64x64 products on one
// four-step 32x32 multiplier, the normalise shifts, a square root, two divisions
// and the control states between them. A pose on an axis goes straight to the
// finish state and is answered with the held command once the output slot is free.
// Throughput: one beat at a time plus any out_ready stall; the next pose is taken
// while a result waits. Reset (rst_n, asynchronous, active low) restores defaults.
`default_nettype none
module superellipse_orbit_velocity_law_core #(
    parameter int POS_FRAC_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] pos_z,
    input  wire logic signed [15:0] heading,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      vel_x,
    output logic signed [15:0]      vel_y,
    output logic signed [15:0]      vel_z,
    output logic signed [15:0]      vel_yaw,
    output logic                    held
);
    import sovl_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sovl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sovl_dp #(
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .heading   (heading),
        .cmd       (cmd),
        .stat      (stat),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .vel_yaw   (vel_yaw),
        .held      (held)
    );

endmodule
`default_nettype wire

### sv/sovl_mul.sv
`default_nettype none
module sovl_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic [127:0]     prod,
    output logic             done
);
    import sovl_pkg::*;

    logic [MUL_W-1:0]  a_reg, b_reg;
    logic [63:0]       pp_reg, pp_next;
    logic [1:0]        pp_sh_reg, pp_sh_next;
    logic [PROD_W-1:0] acc_reg, pp_shifted;
    logic [2:0]        cnt_reg;
    logic              busy_reg, ppv_reg, done_reg;
    logic [31:0]       a_half, b_half;

    always_comb
    begin
        a_half     = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half     = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp_next    = a_half * b_half;
        pp_sh_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        pp_shifted = {64'd0, pp_reg} << {pp_sh_reg, 5'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            ppv_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                if (!cnt_reg[2])
                begin
                    ppv_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 3'd1;
                end
                else
                begin
                    ppv_reg  <= 1'b0;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else
        begin
            if (busy_reg && !cnt_reg[2])
            begin
                pp_reg    <= pp_next;
                pp_sh_reg <= pp_sh_next;
            end
            if (ppv_reg)
                acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### sv/sovl_sqrt.sv
`default_nettype none
module sovl_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [62:0] radicand,
    output logic [31:0]      root,
    output logic             done
);
    import sovl_pkg::*;

    logic [63:0]       rad_reg;
    logic [33:0]       rem_reg, rem2, trial;
    logic [ROOT_W-1:0] root_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg, done_reg, ge;

    always_comb
    begin
        rem2  = {rem_reg[31:0], rad_reg[63:62]};
        trial = {root_reg, 2'b01};
        ge    = rem2 >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= {1'b0, radicand};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= ge ? (rem2 - trial) : rem2;
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### sv/sovl_div.sv
`default_nettype none
module sovl_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [45:0] numer,
    input  wire logic [32:0] denom,
    output logic [45:0]      quot,
    output logic             done
);
    import sovl_pkg::*;

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   rem_reg, rem2;
    logic [5:0]           cnt_reg;
    logic                 busy_reg, done_reg, ge;

    always_comb
    begin
        rem2 = {rem_reg[DIV_DEN_W-1:0], num_reg[DIV_NUM_W-1]};
        ge   = rem2 >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem2 - {1'b0, den_reg}) : rem2;
            num_reg <= {num_reg[DIV_NUM_W-2:0], ge};
        end
    end

    assign quot = num_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### sv/sovl_ctrl.sv
`default_nettype none
module sovl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire sovl_pkg::dp_stat_t stat,
    output sovl_pkg::dp_cmd_t       cmd
);
    import sovl_pkg::*;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;
    div_op_t dv_reg, dv_next;
    logic    out_valid_reg, out_valid_next;
    logic    slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        dv_next    = dv_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = OP_X2;
                    state_next = stat.hold_case ? ST_FINISH : ST_MUL_GO;
                end
            end
            ST_MUL_GO:
                state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
            begin
                if (stat.mul_done)
                begin
                    if (op_reg != OP_WY2)
                        op_next = mul_op_t'(op_reg + 4'd1);
                    unique case (op_reg)
                        OP_R4:   state_next = ST_SUM_A;
                        OP_EPS:  state_next = ST_ADD_WX;
                        OP_WY2:  state_next = ST_SQRT_GO;
                        default: state_next = ST_MUL_GO;
                    endcase
                end
            end
            ST_SUM_A:
                state_next = ST_MUL_GO;
            ST_ADD_WX:
                state_next = ST_ADD_WY;
            ST_ADD_WY:
                state_next = ST_NORM;
            ST_NORM:
            begin
                if (stat.norm_done)
                    state_next = ST_MUL_GO;
            end
            ST_SQRT_GO:
                state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    dv_next    = DV_X;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    unique case (dv_reg)
                        DV_X:
                        begin
                            dv_next    = DV_Y;
                            state_next = ST_DIV_GO;
                        end
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mul_op     = op_reg;
        cmd.div_op     = dv_reg;
        cmd.capture    = (state_reg == ST_IDLE) && in_valid;
        cmd.mul_go     = state_reg == ST_MUL_GO;
        cmd.sum_a      = state_reg == ST_SUM_A;
        cmd.add_wx     = state_reg == ST_ADD_WX;
        cmd.add_wy     = state_reg == ST_ADD_WY;
        cmd.norm_step  = state_reg == ST_NORM;
        cmd.sqrt_go    = state_reg == ST_SQRT_GO;
        cmd.div_go     = state_reg == ST_DIV_GO;
        cmd.load_out   = (state_reg == ST_FINISH) && slot_free;
        in_ready       = state_reg == ST_IDLE;
        out_valid      = out_valid_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_X2;
            dv_reg        <= DV_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### sv/sovl_dp.sv
`default_nettype none
module sovl_dp #(
    parameter int POS_FRAC_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] pos_z,
    input  wire logic signed [15:0] heading,
    input  wire sovl_pkg::dp_cmd_t  cmd,
    output sovl_pkg::dp_stat_t      stat,
    output logic signed [15:0]      vel_x,
    output logic signed [15:0]      vel_y,
    output logic signed [15:0]      vel_z,
    output logic signed [15:0]      vel_yaw,
    output logic                    held
);
    import sovl_pkg::*;

    localparam int EPS_SHL = 3 * POS_FRAC_BITS;

    function automatic logic [W_W:0] sadd(input logic [W_W-1:0] a, input logic sa,
                                          input logic [W_W-1:0] b, input logic sb);
        logic [W_W-1:0] m;
        logic           n;
        if (sa == sb)
        begin
            m = a + b;
            n = sa;
        end
        else if (a >= b)
        begin
            m = a - b;
            n = sa;
        end
        else
        begin
            m = b - a;
            n = sb;
        end
        return {n, m};
    endfunction

    logic [14:0]        radius_reg, gain_reg;
    logic [15:0]        yaw_tgt_reg, alt_tgt_reg;
    logic [15:0]        x_reg, y_reg, z_reg, h_reg;
    logic               held_reg;
    logic [30:0]        x2_reg, y2_reg;
    logic [45:0]        x3_reg, y3_reg;
    logic [60:0]        x4_reg, y4_reg;
    logic [29:0]        r2_reg;
    logic [59:0]        r4_reg;
    logic [61:0]        mag_a_reg;
    logic               neg_a_reg;
    logic [W_W-1:0]     t1x_reg, t2x_reg, t1y_reg, t2y_reg;
    logic [W_W-1:0]     wxm_reg, wym_reg, e_reg;
    logic               wx_neg_reg, wy_neg_reg;
    logic [61:0]        wx2_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [15:0]        vx_reg, vy_reg, yaw_reg, yaw_q_reg;
    logic [15:0]        last_x_reg, last_y_reg, last_z_reg, last_yaw_reg;
    logic [15:0]        out_x_reg, out_y_reg, out_z_reg, out_yaw_reg;
    logic               out_held_reg;

    logic               x_neg, y_neg;
    logic [15:0]        ax, ay;
    logic [14:0]        r_eff;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  mul_p, eps_full;
    logic               mul_done;
    logic [62:0]        s4;
    logic [W_W:0]       wx_sum, wy_sum;
    logic [W_W-1:0]     or_w;
    logic               norm_big;
    logic [ROOT_W-1:0]  root;
    logic               sqrt_done;
    logic [DIV_NUM_W-1:0] div_num, div_q, gx, gy;
    logic [DIV_DEN_W-1:0] div_den;
    logic               div_done;
    logic signed [16:0] dyaw, dz;
    logic [16:0]        dyaw_mag;
    logic [20:0]        yaw_num;
    logic [42:0]        yaw_prod;
    logic [15:0]        yaw_sat;
    logic [15:0]        vz_sat, q16, q_neg;
    logic               den_zero;

    always_comb
    begin
        x_neg    = x_reg[15];
        y_neg    = y_reg[15];
        ax       = x_neg ? (16'd0 - x_reg) : x_reg;
        ay       = y_neg ? (16'd0 - y_reg) : y_reg;
        r_eff    = (radius_reg == 15'd0) ? 15'd1 : radius_reg;
        s4       = {2'b00, x4_reg} + {2'b00, y4_reg};
        wx_sum   = sadd(t1x_reg, neg_a_reg ^ x_neg, t2x_reg, y_neg);
        wy_sum   = sadd(t1y_reg, neg_a_reg ^ y_neg, t2y_reg, !x_neg);
        or_w     = wxm_reg | wym_reg | e_reg;
        norm_big = |or_w[W_W-1:47];
        eps_full = (mul_p << EPS_SHL) >> 34;
        gx       = gain_reg * wxm_reg[30:0];
        gy       = gain_reg * wym_reg[30:0];
        dyaw     = $signed({h_reg[15], h_reg}) - $signed({yaw_tgt_reg[15], yaw_tgt_reg});
        dyaw_mag = dyaw[16] ? (17'd0 - dyaw) : dyaw;
        yaw_num  = {dyaw_mag[15:0], 5'd0};
        yaw_prod = 43'(yaw_num) * 43'(YAW_RECIP);
        if (!dyaw[16])
            yaw_sat = (yaw_q_reg > 16'd32767) ? 16'h7FFF : yaw_q_reg;
        else
            yaw_sat = (yaw_q_reg > 16'd32768) ? 16'h8000 : (16'd0 - yaw_q_reg);
        dz       = $signed({alt_tgt_reg[15], alt_tgt_reg}) - $signed({z_reg[15], z_reg});
        if (dz[16] != dz[15])
            vz_sat = dz[16] ? 16'h8000 : 16'h7FFF;
        else
            vz_sat = dz[15:0];
        den_zero = den_reg == '0;
        q16      = div_q[15:0];
        q_neg    = 16'd0 - q16;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            OP_X2:
            begin
                mul_a = 64'(ax);
                mul_b = 64'(ax);
            end
            OP_Y2:
            begin
                mul_a = 64'(ay);
                mul_b = 64'(ay);
            end
            OP_X3:
            begin
                mul_a = 64'(x2_reg);
                mul_b = 64'(ax);
            end
            OP_Y3:
            begin
                mul_a = 64'(y2_reg);
                mul_b = 64'(ay);
            end
            OP_X4:
            begin
                mul_a = 64'(x3_reg);
                mul_b = 64'(ax);
            end
            OP_Y4:
            begin
                mul_a = 64'(y3_reg);
                mul_b = 64'(ay);
            end
            OP_R2:
            begin
                mul_a = 64'(r_eff);
                mul_b = 64'(r_eff);
            end
            OP_R4:
            begin
                mul_a = 64'(r2_reg);
                mul_b = 64'(r2_reg);
            end
            OP_T1X:
            begin
                mul_a = 64'(mag_a_reg);
                mul_b = 64'(x3_reg);
            end
            OP_T2X:
            begin
                mul_a = 64'(y3_reg);
                mul_b = 64'(r4_reg);
            end
            OP_T1Y:
            begin
                mul_a = 64'(mag_a_reg);
                mul_b = 64'(y3_reg);
            end
            OP_T2Y:
            begin
                mul_a = 64'(x3_reg);
                mul_b = 64'(r4_reg);
            end
            OP_EPS:
            begin
                mul_a = 64'(r4_reg);
                mul_b = EPS_Q32;
            end
            OP_WX2:
            begin
                mul_a = 64'(wxm_reg[30:0]);
                mul_b = 64'(wxm_reg[30:0]);
            end
            OP_WY2:
            begin
                mul_a = 64'(wym_reg[30:0]);
                mul_b = 64'(wym_reg[30:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_num = (cmd.div_op == DV_X) ? gx : gy;
        div_den = den_reg;
    end

    sovl_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_p),
        .done  (mul_done)
    );

    sovl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_go),
        .radicand (sq_reg),
        .root     (root),
        .done     (sqrt_done)
    );

    sovl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_go),
        .numer (div_num),
        .denom (div_den),
        .quot  (div_q),
        .done  (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= 15'd512;
            gain_reg     <= 15'd16384;
            yaw_tgt_reg  <= 16'd5760;
            alt_tgt_reg  <= 16'd256;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            last_z_reg   <= '0;
            last_yaw_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_RADIUS:  radius_reg  <= cfg_wdata[14:0];
                    CFG_GAIN:    gain_reg    <= cfg_wdata[14:0];
                    CFG_YAW_TGT: yaw_tgt_reg <= cfg_wdata;
                    CFG_ALT_TGT: alt_tgt_reg <= cfg_wdata;
                    default:     ;
                endcase
            end
            if (cmd.load_out && !held_reg)
            begin
                last_x_reg   <= vx_reg;
                last_y_reg   <= vy_reg;
                last_z_reg   <= vz_sat;
                last_yaw_reg <= yaw_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg    <= pos_x;
            y_reg    <= pos_y;
            z_reg    <= pos_z;
            h_reg    <= heading;
            held_reg <= (pos_x == 16'sd0) || (pos_y == 16'sd0);
        end
        if (mul_done)
        begin
            unique case (cmd.mul_op)
                OP_X2:   x2_reg  <= mul_p[30:0];
                OP_Y2:   y2_reg  <= mul_p[30:0];
                OP_X3:   x3_reg  <= mul_p[45:0];
                OP_Y3:   y3_reg  <= mul_p[45:0];
                OP_X4:   x4_reg  <= mul_p[60:0];
                OP_Y4:   y4_reg  <= mul_p[60:0];
                OP_R2:   r2_reg  <= mul_p[29:0];
                OP_R4:   r4_reg  <= mul_p[59:0];
                OP_T1X:  t1x_reg <= mul_p[W_W-1:0];
                OP_T2X:  t2x_reg <= mul_p[W_W-1:0];
                OP_T1Y:  t1y_reg <= mul_p[W_W-1:0];
                OP_T2Y:  t2y_reg <= mul_p[W_W-1:0];
                OP_EPS:  e_reg   <= eps_full[W_W-1:0];
                OP_WX2:  wx2_reg <= mul_p[61:0];
                OP_WY2:  sq_reg  <= {1'b0, wx2_reg} + {1'b0, mul_p[61:0]};
                default: ;
            endcase
        end
        if (cmd.sum_a)
        begin
            yaw_q_reg <= yaw_prod[42:YAW_RECIP_SH];
            if (s4 >= {3'd0, r4_reg})
            begin
                mag_a_reg <= 62'(s4 - {3'd0, r4_reg});
                neg_a_reg <= 1'b0;
            end
            else
            begin
                mag_a_reg <= 62'({3'd0, r4_reg} - s4);
                neg_a_reg <= 1'b1;
            end
        end
        if (cmd.add_wx)
        begin
            wxm_reg    <= wx_sum[W_W-1:0];
            wx_neg_reg <= wx_sum[W_W];
        end
        if (cmd.add_wy)
        begin
            wym_reg    <= wy_sum[W_W-1:0];
            wy_neg_reg <= wy_sum[W_W];
        end
        if (cmd.norm_step && !stat.norm_done)
        begin
            if (norm_big)
            begin
                wxm_reg <= wxm_reg >> 16;
                wym_reg <= wym_reg >> 16;
                e_reg   <= e_reg >> 16;
            end
            else
            begin
                wxm_reg <= wxm_reg >> 1;
                wym_reg <= wym_reg >> 1;
                e_reg   <= e_reg >> 1;
            end
        end
        if (sqrt_done)
        begin
            den_reg <= {1'b0, root} + {2'b00, e_reg[30:0]};
            yaw_reg <= yaw_sat;
        end
        if (div_done)
        begin
            unique case (cmd.div_op)
                DV_X:    vx_reg <= den_zero ? 16'd0 : (wx_neg_reg ? q16 : q_neg);
                DV_Y:    vy_reg <= den_zero ? 16'd0 : (wy_neg_reg ? q16 : q_neg);
                default: ;
            endcase
        end
        if (cmd.load_out)
        begin
            out_held_reg <= held_reg;
            out_x_reg    <= held_reg ? last_x_reg   : vx_reg;
            out_y_reg    <= held_reg ? last_y_reg   : vy_reg;
            out_z_reg    <= held_reg ? last_z_reg   : vz_sat;
            out_yaw_reg  <= held_reg ? last_yaw_reg : yaw_reg;
        end
    end

    always_comb
    begin
        stat.hold_case = (pos_x == 16'sd0) || (pos_y == 16'sd0);
        stat.mul_done  = mul_done;
        stat.norm_done = ~|or_w[W_W-1:31];
        stat.sqrt_done = sqrt_done;
        stat.div_done  = div_done;
    end

    assign vel_x   = out_x_reg;
    assign vel_y   = out_y_reg;
    assign vel_z   = out_z_reg;
    assign vel_yaw = out_yaw_reg;
    assign held    = out_held_reg;

endmodule
`default_nettype wire

### tb/superellipse_orbit_velocity_law_checker.sv
`default_nettype none
module superellipse_orbit_velocity_law_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] pos_z,
    input  wire logic signed [15:0] heading,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [15:0] vel_x,
    input  wire logic signed [15:0] vel_y,
    input  wire logic signed [15:0] vel_z,
    input  wire logic signed [15:0] vel_yaw,
    input  wire logic               held,
    output int                      mismatches,
    output int                      pending
);
    import sovl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_FRAC_BITS = 8;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic signed [15:0] vyaw;
        logic               hold;
    } vel_cmd_t;

    vel_cmd_t   cmd_q[$];
    vel_cmd_t   last_cmd;
    logic [14:0] radius;
    logic [14:0] gain;
    logic signed [15:0] yaw_tgt;
    logic signed [15:0] alt_tgt;

    assign pending = cmd_q.size();

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] scaled_axis(logic signed [127:0] w, int s,
                                                       longint unsigned den);
        logic [127:0]    mag;
        longint unsigned q;
        mag = w < 0 ? -w : w;
        mag = mag >> s;
        if (den == 0) return 16'sd0;
        q = (64'(gain) * mag[63:0]) / den;
        return w < 0 ? sat16(longint'(q)) : sat16(-longint'(q));
    endfunction

    function automatic vel_cmd_t orbit_command(logic signed [15:0] x, logic signed [15:0] y,
                                               logic signed [15:0] z, logic signed [15:0] h);
        vel_cmd_t           c;
        longint             xl, yl, rl, a;
        logic signed [127:0] a128, x3, y3, r4, wx_s, wy_s;
        logic [127:0]       mx, ex, mwx, mwy;
        longint unsigned    wx, wy, e, den;
        int                 bl, s;
        if (x == 0 || y == 0) begin
            c = last_cmd;
            c.hold = 1'b1;
            return c;
        end
        xl = x;
        yl = y;
        rl = radius == 0 ? 1 : radius;
        a = xl*xl*xl*xl + yl*yl*yl*yl - rl*rl*rl*rl;
        a128 = a;
        x3 = xl*xl*xl;
        y3 = yl*yl*yl;
        r4 = rl*rl*rl*rl;
        wx_s = a128*x3 + y3*r4;
        wy_s = a128*y3 - x3*r4;
        ex = ((128'(r4) * 128'(EPS_Q32)) << (3*POS_FRAC_BITS)) >> 34;
        mwx = wx_s < 0 ? -wx_s : wx_s;
        mwy = wy_s < 0 ? -wy_s : wy_s;
        mx = mwx;
        if (mwy > mx) mx = mwy;
        if (ex > mx) mx = ex;
        bl = 0;
        for (int i = 127; i >= 0; i--)
            if (mx[i] && bl == 0) bl = i + 1;
        s = bl > 31 ? bl - 31 : 0;
        wx = 64'(mwx >> s);
        wy = 64'(mwy >> s);
        e = 64'(ex >> s);
        den = floor_sqrt(wx*wx + wy*wy) + e;
        c.vx = scaled_axis(wx_s, s, den);
        c.vy = scaled_axis(wy_s, s, den);
        c.vz = sat16(longint'(alt_tgt) - longint'(z));
        c.vyaw = sat16((longint'(h) - longint'(yaw_tgt)) * 32 / 45);
        c.hold = 1'b0;
        return c;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n) begin
        vel_cmd_t w;
        if (!rst_n) begin
            radius   <= 15'd512;
            gain     <= 15'd16384;
            yaw_tgt  <= 16'sd5760;
            alt_tgt  <= 16'sd256;
            last_cmd <= '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0};
            cmd_q.delete();
        end
        else begin
            if (out_valid && out_ready) begin
                if (cmd_q.size() == 0) begin
                    report("unexpected beat, vel_x", vel_x, 0);
                end
                else begin
                    w = cmd_q.pop_front();
                    if (vel_x !== w.vx) report("vel_x", vel_x, w.vx);
                    if (vel_y !== w.vy) report("vel_y", vel_y, w.vy);
                    if (vel_z !== w.vz) report("vel_z", vel_z, w.vz);
                    if (vel_yaw !== w.vyaw) report("vel_yaw", vel_yaw, w.vyaw);
                    if (held !== w.hold) report("held", held, w.hold);
                end
            end
            if (in_valid && in_ready) begin
                w = orbit_command(pos_x, pos_y, pos_z, heading);
                cmd_q.push_back(w);
                if (!w.hold) last_cmd <= w;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_RADIUS:  radius  <= cfg_wdata[14:0];
                    CFG_GAIN:    gain    <= cfg_wdata[14:0];
                    CFG_YAW_TGT: yaw_tgt <= cfg_wdata;
                    CFG_ALT_TGT: alt_tgt <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

### tb/tb_superellipse_orbit_velocity_law_core.sv
`default_nettype none
module tb_superellipse_orbit_velocity_law_core;
    import sovl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd6;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_addr = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic signed [15:0] pos_z = '0;
    logic signed [15:0] heading = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] vel_x, vel_y, vel_z, vel_yaw;
    logic               held;
    int                 mismatches;
    int                 pending;
    int                 radius_now = 512;
    int                 stall_left = 0;
    int                 stall_mode = 0;

    always #1 clk = ~clk;

    superellipse_orbit_velocity_law_core dut (.*);

    superellipse_orbit_velocity_law_checker chk (.*);

    initial
    begin
        #3ms;
        $display("Verification failed");
        $finish;
    end

    // receiver: free-running, random, or mostly stalled stretches
    always @(negedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 120);
        end
        stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        if (idx == CFG_RADIUS) radius_now = int'(val[14:0]);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_pose(int x, int y, int z, int h, bit keep);
        pos_x = 16'(x);
        pos_y = 16'(y);
        pos_z = 16'(z);
        heading = 16'(h);
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (!keep) in_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic int pick_coord();
        int r;
        int k;
        r = radius_now == 0 ? 1 : radius_now;
        k = $urandom_range(0, 9);
        if (k < 6) begin
            r = r + $signed($urandom_range(0, r / 2 + 2)) - r / 4 - 1;
            if (r > 32767) r = 32767;
            return $urandom_range(0, 1) ? r : -r;
        end
        if (k < 8) return $signed($urandom_range(0, 65535)) - 32768;
        if (k < 9) return $signed($urandom_range(0, 16)) - 8;
        return 0;
    endfunction

    task automatic random_burst(int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(negedge clk);
            end
            burst--;
            send_pose(pick_coord(), pick_coord(), $signed($urandom_range(0, 65535)) - 32768,
                      $signed($urandom_range(0, 46080)) - 23040, burst != 0 && i != n - 1);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // hold on axes before any command, then extremes
        send_pose(0, 100, 0, 0, 0);
        send_pose(512, 512, 256, 5760, 0);
        send_pose(32767, 32767, 32767, 23040, 1);
        send_pose(-32768, -32768, -32768, -23040, 1);
        send_pose(-32768, 32767, 0, 0, 0);
        send_pose(1, 1, -1, 1, 0);
        send_pose(-1, 1, 1, -1, 0);
        send_pose(0, 0, 5, 5, 0);
        send_pose(300, 0, 7, 7, 1);
        send_pose(362, -362, 100, 100, 0);
        send_pose(-700, 200, 256, 5760, 0);
        drain();

        write_reg(CFG_RADIUS, 16'd1);
        write_reg(CFG_GAIN, 16'd32767);
        write_reg(CFG_YAW_TGT, -16'sd23040);
        write_reg(CFG_ALT_TGT, -16'sd32768);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_pose(1, 1, 32767, 23040, 0);
        send_pose(-1, -1, -32768, -23040, 0);
        send_pose(32767, -32768, 100, 0, 0);
        send_pose(2, 3, 0, 0, 0);
        drain();

        write_reg(CFG_RADIUS, 16'h7FFF);
        write_reg(CFG_GAIN, 16'd0);
        write_reg(CFG_YAW_TGT, 16'sd23040);
        write_reg(CFG_ALT_TGT, 16'sd32767);
        send_pose(32767, 32767, -32768, -23040, 0);
        send_pose(-32768, 1, 32767, 23040, 0);
        drain();
        write_reg(CFG_GAIN, 16'hFFFF);
        send_pose(-32768, 32767, 0, 0, 0);
        send_pose(100, -100, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_RADIUS, 16'($urandom_range(1, ph == 5 ? 32767 : 4000)));
            write_reg(CFG_GAIN, 16'($urandom_range(0, 32767)));
            write_reg(CFG_YAW_TGT, 16'($signed($urandom_range(0, 46080)) - 23040));
            write_reg(CFG_ALT_TGT, 16'($urandom_range(0, 65535)));
            random_burst(72);
            drain();
        end

        repeat (400) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
sv/sovl_pkg.sv
sv/sovl_mul.sv
sv/sovl_sqrt.sv
sv/sovl_div.sv
sv/sovl_ctrl.sv
sv/sovl_dp.sv
sv/superellipse_orbit_velocity_law_core.sv
tb/superellipse_orbit_velocity_law_checker.sv
tb/tb_superellipse_orbit_velocity_law_core.sv
